// ----- hw/rtl/plfl_pkg.sv -----
`timescale 1ns / 1ps

package plfl_pkg;

    // table geometry
    localparam int MAX_SEG     = 256;
    localparam int TABLE_DEPTH = MAX_SEG + 1;

    // field widths
    localparam int IDX_W   = 9;
    localparam int DATA_W  = 33;
    localparam int COORD_W = 32;
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 2;

    // stream packing
    localparam int S_IDX_LSB   = 0;
    localparam int S_DATA_LSB  = S_IDX_LSB + IDX_W;
    localparam int S_COORD_LSB = S_DATA_LSB + DATA_W;
    localparam int S_USED_W    = S_COORD_LSB + COORD_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;
    localparam int M_USED_W    = VAL_W + IDX_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SEGMENTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALUES_AT_VX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNIFORM_GRID = 3'd4;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_LOAD_VALUE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_POSITION = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY         = 2'd2;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- hw/rtl/plfl_ram.sv -----
`timescale 1ns / 1ps

module plfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/plfl_div.sv -----
`timescale 1ns / 1ps

module plfl_div #(
    parameter int QW = 25,
    parameter int VW = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [QW+VW-1:0]      dividend,
    input  logic [VW-1:0]         divisor,
    output logic [QW-1:0]         quotient,
    output plfl_pkg::div_stat_t   stat
);

    import plfl_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [QW-1:0] low_reg, low_next;
    logic [VW-1:0] divisor_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic [VW:0]   trial_diff;
    logic          fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial      = {rem_reg, low_reg[QW-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        fits       = !trial_diff[VW];
    end

    // step sequencing
    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[QW+VW-1:QW];
            low_next  = dividend[QW-1:0];
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_diff[VW-1:0] : trial[VW-1:0];
            low_next = {low_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign quotient  = low_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- hw/rtl/piecewise_linear_field_lookup_unit.sv -----
`timescale 1ns / 1ps
// load beats (value or position entry) are written in the cycle they are taken; the next beat is taken the cycle after
// uniform-grid query: paced by the bit-serial divider that follows the prep state, then value reads and the blend
// non-uniform query: paced by the one-entry-per-cycle position scan, then (vertex values only) the
// bracketing position reads and the same divider; end-of-domain queries skip the scan and the divider
// one query at a time; the result register lets the next beat in while a result waits
// reset clears control and config registers to defaults; tables are not cleared

module piecewise_linear_field_lookup_unit #(
    parameter int INTERP_FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // s_tdata: entry_index, entry_data, query_coordinate, zero pad
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [plfl_pkg::S_TDATA_W-1:0]        s_tdata,
    // s_tuser: mode
    input  logic [plfl_pkg::MODE_W-1:0]           s_tuser,
    // m_tdata: field_value, segment_index, zero pad
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [plfl_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                  cfg_we,
    input  logic [plfl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [plfl_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import plfl_pkg::*;

    localparam int IFB = INTERP_FRAC_BITS;
    localparam int QW  = IDX_W + IFB;
    localparam int DW  = QW + COORD_W;
    localparam int NUM_W = COORD_W + IDX_W;
    localparam int PW  = DATA_W + IFB + 1;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (IFB - 1);

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_PREP     = 15'h0002,
        S_DIV_GO   = 15'h0004,
        S_DIV_WAIT = 15'h0008,
        S_SCAN     = 15'h0010,
        S_POS_L    = 15'h0020,
        S_POS_R    = 15'h0040,
        S_POS_W    = 15'h0080,
        S_POS_CHK  = 15'h0100,
        S_VAL_L    = 15'h0200,
        S_VAL_R    = 15'h0400,
        S_VAL_W    = 15'h0800,
        S_MUL      = 15'h1000,
        S_SUM      = 15'h2000,
        S_DONE     = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [COORD_W-1:0] domain_min_reg;
    logic [COORD_W-1:0] domain_max_reg;
    logic [IDX_W-1:0]   num_segments_reg;
    logic               values_at_vertices_reg;
    logic               uniform_grid_reg;

    // input beat fields
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_data;
    logic [COORD_W-1:0]       query_coordinate;
    logic                     in_beat;

    // query working registers
    logic [COORD_W-1:0]   x_reg, x_next;
    logic [IDX_W-1:0]     rd_a_reg, rd_a_next;
    logic [IDX_W-1:0]     rd_b_reg, rd_b_next;
    logic [IDX_W-1:0]     seg_idx_reg, seg_idx_next;
    logic [IFB-1:0]       f_reg, f_next;
    logic [DW-1:0]        dividend_reg, dividend_next;
    logic [COORD_W-1:0]   divisor_reg, divisor_next;
    logic [IDX_W-1:0]     issue_reg, issue_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [COORD_W-1:0]   pl_reg, pl_next;
    logic [COORD_W-1:0]   pr_reg, pr_next;
    logic [VAL_W-1:0]     vm_reg, vm_next;
    logic signed [DATA_W-1:0] diff_reg, diff_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [VAL_W-1:0]     res_reg, res_next;

    // result register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]     field_value_reg;
    logic [IDX_W-1:0]     segment_index_reg;
    logic                 out_free;

    // derived segment counts
    logic [IDX_W-1:0] ns_eff;
    logic [IDX_W-1:0] nv;
    logic [IDX_W-1:0] last_idx;

    // tables
    logic               val_we, pos_we;
    logic               val_re, pos_re;
    logic [IDX_W-1:0]   val_raddr, pos_raddr;
    logic [VAL_W-1:0]   val_rdata, pos_rdata;

    // divider
    logic               div_start;
    logic [QW-1:0]      div_q;
    div_stat_t          div_stat;

    // scan and datapath helpers
    logic                 scan_issue;
    logic                 scan_hit;
    logic                 scan_end;
    logic [IDX_W-1:0]     found_i;
    logic [IDX_W-1:0]     seg_left;
    logic [IDX_W-1:0]     vx_right;
    logic [COORD_W-1:0]   x_off;
    logic [NUM_W-1:0]     mul_num;
    logic signed [PW-1:0] round_sum;
    logic signed [PW-1:0] round_shift;

    // beat unpacking
    assign mode             = s_tuser;
    assign entry_index      = s_tdata[S_IDX_LSB +: IDX_W];
    assign entry_data       = s_tdata[S_DATA_LSB +: DATA_W];
    assign query_coordinate = s_tdata[S_COORD_LSB +: COORD_W];

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            domain_min_reg         <= '0;
            domain_max_reg         <= '1;
            num_segments_reg       <= IDX_W'(1);
            values_at_vertices_reg <= 1'b1;
            uniform_grid_reg       <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DOMAIN_MIN:   domain_min_reg         <= cfg_data[COORD_W-1:0];
                REG_DOMAIN_MAX:   domain_max_reg         <= cfg_data[COORD_W-1:0];
                REG_NUM_SEGMENTS: num_segments_reg       <= cfg_data[IDX_W-1:0];
                REG_VALUES_AT_VX: values_at_vertices_reg <= cfg_data[0];
                REG_UNIFORM_GRID: uniform_grid_reg       <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // clamp segment count, count value entries
    always_comb
    begin
        if (num_segments_reg == '0)
        begin
            ns_eff = IDX_W'(1);
        end
        else if (num_segments_reg > IDX_W'(MAX_SEG))
        begin
            ns_eff = IDX_W'(MAX_SEG);
        end
        else
        begin
            ns_eff = num_segments_reg;
        end
        nv       = ns_eff + IDX_W'(values_at_vertices_reg);
        last_idx = nv - IDX_W'(1);
    end

    // table loads
    assign val_we = in_beat && (mode == MODE_LOAD_VALUE) && (entry_index < IDX_W'(TABLE_DEPTH));
    assign pos_we = in_beat && (mode == MODE_LOAD_POSITION) &&
                    (entry_index < IDX_W'(TABLE_DEPTH));

    plfl_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (entry_index),
        .wdata (entry_data[VAL_W-1:0]),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    plfl_ram #(
        .WIDTH (COORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_position_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (entry_index),
        .wdata (entry_data[COORD_W-1:0]),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // shared serial divider
    assign div_start = (state_reg == S_DIV_GO);

    plfl_div #(
        .QW (QW),
        .VW (COORD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // table read ports
    assign scan_issue = (state_reg == S_SCAN) && (issue_reg < nv);
    assign pos_re     = scan_issue || (state_reg == S_POS_L) || (state_reg == S_POS_R);
    assign val_re     = (state_reg == S_VAL_L) || (state_reg == S_VAL_R);
    assign val_raddr  = (state_reg == S_VAL_R) ? rd_b_reg : rd_a_reg;

    always_comb
    begin
        pos_raddr = rd_a_reg;
        if (state_reg == S_SCAN)
        begin
            pos_raddr = issue_reg;
        end
        else if (state_reg == S_POS_R)
        begin
            pos_raddr = rd_b_reg;
        end
    end

    // position scan result and segment clamping
    always_comb
    begin
        scan_hit = cmp_valid_reg && (x_reg < pos_rdata);
        scan_end = cmp_valid_reg && !scan_hit && (cmp_idx_reg == last_idx);
        found_i  = scan_hit ? cmp_idx_reg : nv;
        // segment values: entry left of the first position above x
        seg_left = (found_i == '0) ? '0 : found_i - IDX_W'(1);
        if (seg_left > ns_eff - IDX_W'(1))
        begin
            seg_left = ns_eff - IDX_W'(1);
        end
        // vertex values: right vertex kept inside 1..segments
        vx_right = found_i;
        if (found_i == '0)
        begin
            vx_right = IDX_W'(1);
        end
        else if (found_i > ns_eff)
        begin
            vx_right = ns_eff;
        end
    end

    // scaled offset for the uniform grid
    assign x_off   = x_reg - domain_min_reg;
    assign mul_num = NUM_W'(x_off) * NUM_W'(ns_eff);

    // rounding of the blend product, halves toward plus infinity
    always_comb
    begin
        round_sum   = prod_reg + ROUND_HALF;
        round_shift = round_sum >>> IFB;
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        rd_a_next      = rd_a_reg;
        rd_b_next      = rd_b_reg;
        seg_idx_next   = seg_idx_reg;
        f_next         = f_reg;
        dividend_next  = dividend_reg;
        divisor_next   = divisor_reg;
        issue_next     = issue_reg;
        cmp_valid_next = scan_issue;
        cmp_idx_next   = issue_reg;
        pl_next        = pl_reg;
        pr_next        = pr_reg;
        vm_next        = vm_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat && (mode == MODE_QUERY))
                begin
                    x_next     = query_coordinate;
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                f_next = '0;
                if (uniform_grid_reg)
                begin
                    if (x_reg <= domain_min_reg)
                    begin
                        rd_a_next    = '0;
                        rd_b_next    = '0;
                        seg_idx_next = '0;
                        state_next   = S_VAL_L;
                    end
                    else if (x_reg >= domain_max_reg)
                    begin
                        rd_a_next    = last_idx;
                        rd_b_next    = last_idx;
                        seg_idx_next = last_idx;
                        state_next   = S_VAL_L;
                    end
                    else
                    begin
                        dividend_next = {mul_num, {IFB{1'b0}}};
                        divisor_next  = domain_max_reg - domain_min_reg;
                        state_next    = S_DIV_GO;
                    end
                end
                else
                begin
                    if (x_reg >= domain_max_reg)
                    begin
                        rd_a_next    = last_idx;
                        rd_b_next    = last_idx;
                        seg_idx_next = last_idx;
                        state_next   = S_VAL_L;
                    end
                    else if (x_reg <= domain_min_reg)
                    begin
                        rd_a_next    = '0;
                        rd_b_next    = '0;
                        seg_idx_next = '0;
                        state_next   = S_VAL_L;
                    end
                    else
                    begin
                        issue_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (uniform_grid_reg)
                    begin
                        // quotient holds segment in the high bits, fraction below
                        seg_idx_next = div_q[QW-1:IFB];
                        rd_a_next    = div_q[QW-1:IFB];
                        if (values_at_vertices_reg)
                        begin
                            rd_b_next = div_q[QW-1:IFB] + IDX_W'(1);
                            f_next    = div_q[IFB-1:0];
                        end
                        else
                        begin
                            rd_b_next = div_q[QW-1:IFB];
                            f_next    = '0;
                        end
                    end
                    else
                    begin
                        f_next = div_q[IFB-1:0];
                    end
                    state_next = S_VAL_L;
                end
            end

            S_SCAN:
            begin
                if (scan_issue)
                begin
                    issue_next = issue_reg + IDX_W'(1);
                end
                if (scan_hit || scan_end)
                begin
                    if (values_at_vertices_reg)
                    begin
                        rd_a_next    = vx_right - IDX_W'(1);
                        rd_b_next    = vx_right;
                        seg_idx_next = vx_right - IDX_W'(1);
                        state_next   = S_POS_L;
                    end
                    else
                    begin
                        rd_a_next    = seg_left;
                        rd_b_next    = seg_left;
                        seg_idx_next = seg_left;
                        state_next   = S_VAL_L;
                    end
                end
            end

            S_POS_L:
            begin
                state_next = S_POS_R;
            end

            S_POS_R:
            begin
                pl_next    = pos_rdata;
                state_next = S_POS_W;
            end

            S_POS_W:
            begin
                pr_next    = pos_rdata;
                state_next = S_POS_CHK;
            end

            S_POS_CHK:
            begin
                if (x_reg <= pl_reg)
                begin
                    rd_b_next  = rd_a_reg;
                    state_next = S_VAL_L;
                end
                else if (x_reg >= pr_reg)
                begin
                    rd_a_next  = rd_b_reg;
                    state_next = S_VAL_L;
                end
                else
                begin
                    dividend_next = {{IDX_W{1'b0}}, x_reg - pl_reg, {IFB{1'b0}}};
                    divisor_next  = pr_reg - pl_reg;
                    state_next    = S_DIV_GO;
                end
            end

            S_VAL_L:
            begin
                state_next = S_VAL_R;
            end

            S_VAL_R:
            begin
                vm_next    = val_rdata;
                state_next = S_VAL_W;
            end

            S_VAL_W:
            begin
                diff_next  = $signed({val_rdata[VAL_W-1], val_rdata}) -
                             $signed({vm_reg[VAL_W-1], vm_reg});
                state_next = S_MUL;
            end

            S_MUL:
            begin
                prod_next  = diff_reg * $signed({1'b0, f_reg});
                state_next = S_SUM;
            end

            S_SUM:
            begin
                res_next   = vm_reg + round_shift[VAL_W-1:0];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register handshake
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if ((state_reg == S_DONE) && out_free)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            issue_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            cmp_valid_reg <= cmp_valid_next;
            issue_reg     <= issue_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        rd_a_reg     <= rd_a_next;
        rd_b_reg     <= rd_b_next;
        seg_idx_reg  <= seg_idx_next;
        f_reg        <= f_next;
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        cmp_idx_reg  <= cmp_idx_next;
        pl_reg       <= pl_next;
        pr_reg       <= pr_next;
        vm_reg       <= vm_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            field_value_reg   <= res_reg;
            segment_index_reg <= seg_idx_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, segment_index_reg, field_value_reg};

    // divider is never restarted while it works
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
    else $error("divider started while busy");

    // a finished division is always consumed the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_WAIT) && div_stat.done |=> (state_reg == S_VAL_L))
    else $error("division result dropped");

    // interior answers only ever divide by a nonzero span
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_GO) |-> (divisor_reg != '0))
    else $error("zero divisor");

    // reported segment stays within the value entries in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (seg_idx_reg <= last_idx))
    else $error("segment index beyond last entry");

endmodule
